>>> src/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg: shared types and codes of the page frame allocator
// Operation, status and register codes and the sequencer state type.
// ----------------------------------------------------------------------------
package pfa_pkg;

	typedef enum logic [2:0] {
		OP_ALLOC      = 3'd0,
		OP_FREE       = 3'd1,
		OP_INCR       = 3'd2,
		OP_DECR       = 3'd3,
		OP_READ_COUNT = 3'd4,
		OP_FREE_TOTAL = 3'd5,
		OP_INIT_FREE  = 3'd6,
		OP_UNUSED     = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_OUT_OF_MEM  = 2'd1,
		ST_BAD_ADDRESS = 2'd2,
		ST_STACK_FULL  = 2'd3
	} status_t;

	localparam logic REG_LOWEST_FREE_PAGE = 1'b0;
	localparam logic REG_TOP_PAGE         = 1'b1;

	localparam logic [16:0] TOP_PAGE_RESET = 17'd57344;

	typedef enum logic [1:0] {
		FSM_CLEAR,
		FSM_IDLE,
		FSM_EXEC
	} fsm_t;

endpackage

>>> src/page_frame_allocator_refcount_unit.sv
// ----------------------------------------------------------------------------
// page_frame_allocator_refcount_unit: page frame allocator with ref counts
// Free pages sit on a LIFO stack in one RAM, reference counts in another.
//
//   channel | direction | handshake          | content
//   s_*     | in        | s_tvalid/s_tready  | opcode, page address
//   m_*     | out       | m_tvalid/m_tready  | status, alloc address, count, free total
//   cfg_*   | in        | cfg_valid/cfg_ready| register index, write data
//
// Each item is read in its accept cycle, from the count RAM and the top of the
// stack RAM; the FSM_EXEC state then modifies and writes both back.
// After reset a clearing pass zeroes every entry of the count RAM, during
// which no item is accepted; configuration writes are taken at any time.
// A full output register holds the write-back cycle until the result is taken.
// ----------------------------------------------------------------------------
module page_frame_allocator_refcount_unit
	import pfa_pkg::*;
#(
	parameter int NUM_PAGES  = 65536,
	parameter int PAGE_SHIFT = 12,
	parameter int COUNT_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // opcode[2:0], page_address[34:3], zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // status[1:0], alloc_address[33:2],
	                               // ref_count[41:34], free_total[58:42], zero fill
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [16:0] cfg_data
);

	localparam int PG_W    = $clog2(NUM_PAGES);
	localparam int DEPTH_W = $clog2(NUM_PAGES + 1);
	localparam logic [DEPTH_W-1:0]    FullDepth = DEPTH_W'(NUM_PAGES);
	localparam logic [32:0]           NumPagesW = 33'(NUM_PAGES);
	localparam logic [COUNT_BITS-1:0] CountMax  = '1;

	fsm_t state_q, state_d;

	logic [15:0]         lowest_q;
	logic [16:0]         top_q;
	logic [DEPTH_W-1:0]  depth_q, depth_d;
	logic [DEPTH_W-1:0]  clr_q;
	logic [DEPTH_W-1:0]  depth_m1;

	op_t                 op_s1;
	logic [PG_W-1:0]     pg_s1;
	logic                valid_s1;

	logic                out_valid_q;
	logic [58:0]         out_data_q;

	logic [2:0]          in_op;
	logic [31:0]         in_addr;
	logic [32:0]         in_pg;
	logic                in_valid;
	logic                accept;
	logic                exec_go;
	logic                clr_last;
	logic                clr_we;

	logic                cnt_we, cnt_re;
	logic [PG_W-1:0]     cnt_waddr;
	logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;
	logic                stk_we, stk_re;
	logic [PG_W-1:0]     stk_rdata;

	logic                x_cnt_we;
	logic [PG_W-1:0]     x_cnt_addr;
	logic [COUNT_BITS-1:0] x_cnt_data;
	logic                x_push;
	logic [1:0]          x_status;
	logic [31:0]         x_alloc;
	logic [COUNT_BITS-1:0] x_count;
	logic [COUNT_BITS-1:0] c_dec;

	assign in_op    = s_tdata[2:0];
	assign in_addr  = s_tdata[34:3];
	assign in_pg    = 33'(in_addr >> PAGE_SHIFT);
	assign in_valid = (in_addr[PAGE_SHIFT-1:0] == '0) && (in_pg >= 33'(lowest_q))
		&& (in_pg < 33'(top_q)) && (in_pg < NumPagesW);
	assign depth_m1 = depth_q - DEPTH_W'(1);
	assign clr_last = (clr_q == FullDepth - DEPTH_W'(1));
	assign cfg_ready = 1'b1;

	// Sequencer: next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_CLEAR: begin
				if (clr_last) begin
					state_d = FSM_IDLE;
				end
			end
			FSM_IDLE: begin
				if (s_tvalid) begin
					state_d = FSM_EXEC;
				end
			end
			FSM_EXEC: begin
				if (!out_valid_q || m_tready) begin
					state_d = FSM_IDLE;
				end
			end
			default: state_d = FSM_CLEAR;
		endcase
	end

	// Sequencer: outputs.
	always_comb begin
		s_tready = 1'b0;
		clr_we   = 1'b0;
		exec_go  = 1'b0;
		case (state_q)
			FSM_CLEAR: clr_we = 1'b1;
			FSM_IDLE:  s_tready = 1'b1;
			FSM_EXEC:  exec_go = !out_valid_q || m_tready;
			default:   s_tready = 1'b0;
		endcase
	end

	assign accept = s_tvalid && s_tready;
	assign cnt_re = accept;
	assign stk_re = accept;

	// Modify step of the read-modify-write.
	always_comb begin
		x_cnt_we   = 1'b0;
		x_cnt_addr = pg_s1;
		x_cnt_data = cnt_rdata;
		x_push     = 1'b0;
		x_status   = ST_OK;
		x_alloc    = '0;
		x_count    = '0;
		depth_d    = depth_q;
		c_dec      = (cnt_rdata != '0) ? cnt_rdata - COUNT_BITS'(1) : '0;
		case (op_s1)
			OP_ALLOC: begin
				if (depth_q == '0) begin
					x_status = ST_OUT_OF_MEM;
				end else begin
					x_cnt_we   = 1'b1;
					x_cnt_addr = stk_rdata;
					x_cnt_data = COUNT_BITS'(1);
					x_count    = COUNT_BITS'(1);
					x_alloc    = 32'(stk_rdata) << PAGE_SHIFT;
					depth_d    = depth_m1;
				end
			end
			OP_FREE_TOTAL, OP_UNUSED: begin
				x_status = ST_OK;
			end
			default: begin
				if (!valid_s1) begin
					x_status = ST_BAD_ADDRESS;
				end else begin
					x_count = cnt_rdata;
					case (op_s1)
						OP_FREE: begin
							if (c_dec == '0 && depth_q == FullDepth) begin
								x_status = ST_STACK_FULL;
							end else begin
								x_cnt_we   = 1'b1;
								x_cnt_data = c_dec;
								x_count    = c_dec;
								if (c_dec == '0) begin
									x_push  = 1'b1;
									depth_d = depth_q + DEPTH_W'(1);
								end
							end
						end
						OP_INCR: begin
							x_cnt_we   = 1'b1;
							x_cnt_data = (cnt_rdata != CountMax) ?
								cnt_rdata + COUNT_BITS'(1) : cnt_rdata;
							x_count    = x_cnt_data;
						end
						OP_DECR: begin
							x_cnt_we   = 1'b1;
							x_cnt_data = c_dec;
							x_count    = c_dec;
						end
						OP_INIT_FREE: begin
							if (depth_q == FullDepth) begin
								x_status = ST_STACK_FULL;
							end else begin
								x_cnt_we   = 1'b1;
								x_cnt_data = '0;
								x_count    = '0;
								x_push     = 1'b1;
								depth_d    = depth_q + DEPTH_W'(1);
							end
						end
						default: x_count = cnt_rdata;
					endcase
				end
			end
		endcase
	end

	assign cnt_we    = clr_we || (exec_go && x_cnt_we);
	assign cnt_waddr = clr_we ? clr_q[PG_W-1:0] : x_cnt_addr;
	assign cnt_wdata = clr_we ? '0 : x_cnt_data;
	assign stk_we    = exec_go && x_push;

	pfa_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (NUM_PAGES)
	) u_count_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (cnt_re),
		.raddr (in_pg[PG_W-1:0]),
		.rdata (cnt_rdata)
	);

	pfa_ram #(
		.WIDTH (PG_W),
		.DEPTH (NUM_PAGES)
	) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (depth_q[PG_W-1:0]),
		.wdata (pg_s1),
		.re    (stk_re),
		.raddr (depth_m1[PG_W-1:0]),
		.rdata (stk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_CLEAR;
			clr_q       <= '0;
			depth_q     <= '0;
			lowest_q    <= '0;
			top_q       <= TOP_PAGE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clr_we) begin
				clr_q <= clr_q + DEPTH_W'(1);
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_LOWEST_FREE_PAGE) begin
					lowest_q <= cfg_data[15:0];
				end else begin
					top_q <= cfg_data;
				end
			end
			if (exec_go) begin
				depth_q     <= depth_d;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= op_t'(in_op);
			pg_s1    <= in_pg[PG_W-1:0];
			valid_s1 <= in_valid;
		end
		if (exec_go) begin
			out_data_q <= {17'(depth_d), 8'(x_count), x_alloc, x_status};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, out_data_q};

`ifndef SYNTHESIS
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= FullDepth)
		else $error("free stack depth above the page count");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("second item accepted while one is in progress");

	a_depth_step: assert property (@(posedge clk) disable iff (!arst_n)
		exec_go |=> (depth_q == $past(depth_q) || depth_q == $past(depth_q) + DEPTH_W'(1)
			|| depth_q == $past(depth_q) - DEPTH_W'(1)))
		else $error("free stack depth moved by more than one entry");

	a_no_item_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_CLEAR) |-> !m_tvalid)
		else $error("result produced during the clearing pass");
`endif

endmodule

>>> src/pfa_ram.sv
// ----------------------------------------------------------------------------
// pfa_ram: generic single-clock RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module pfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
